// ----- rtl/core/rpp_pkg.sv -----
// Package for the rack position PID controller: field widths, parameter
// defaults, register reset values and register index codes.
// No dependencies.
`default_nettype none

package rpp_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LimW   = 10;
  localparam int unsigned TolW   = 8;
  localparam int unsigned DriveW = 11;
  localparam int unsigned IntW   = 11;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // Defaults for the top-level parameters.
  localparam int PosMinDef        = 0;
  localparam int PosMaxDef        = 1800;
  localparam int IntegralLimitDef = 1000;
  localparam int UpdateMsDef      = 5;

  // Integration only runs while the error magnitude is below this band.
  localparam int NearBand = 250;

  localparam logic [GainW-1:0] GainPRst     = 16'd512;
  localparam logic [GainW-1:0] GainIRst     = 16'd77;
  localparam logic [GainW-1:0] GainDRst     = 16'd1280;
  localparam logic [LimW-1:0]  LimitUpRst   = 10'd600;
  localparam logic [LimW-1:0]  LimitDownRst = 10'd250;
  localparam logic [LimW-1:0]  HoldDriveRst = 10'd100;
  localparam logic [LimW-1:0]  MinDriveRst  = 10'd80;
  localparam logic [TolW-1:0]  ToleranceRst = 8'd10;

  typedef enum logic [2:0] {
    RegGainP     = 3'd0,
    RegGainI     = 3'd1,
    RegGainD     = 3'd2,
    RegLimitUp   = 3'd3,
    RegLimitDown = 3'd4,
    RegHoldDrive = 3'd5,
    RegMinDrive  = 3'd6,
    RegTolerance = 3'd7
  } reg_idx_e;

endpackage

`default_nettype wire

// ----- rtl/core/rpp_if.sv -----
// Handshake channels of the rack position PID controller: the encoder sample
// channel and the drive result channel. Depends on rpp_pkg.
`default_nettype none

interface rpp_sample_if import rpp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PosW-1:0]  position;
  logic signed [PosW-1:0]  target;
  logic        [TimeW-1:0] now_ms;
  logic                    clear;

  modport source (output valid, position, target, now_ms, clear, input ready);
  modport sink   (input valid, position, target, now_ms, clear, output ready);
endinterface

interface rpp_result_if import rpp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     drive_write;
  logic signed [DriveW-1:0] drive;
  logic                     reached;

  modport source (output valid, drive_write, drive, reached, input ready);
  modport sink   (input valid, drive_write, drive, reached, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rack_position_pid.sv -----
// Rack position PID controller top level: sample register, combinational PID
// update with controller state, result register and APB register file.
// Depends on rpp_pkg and the channel interfaces in rpp_if.sv.
//
//  Channel   Dir  Handshake          Payload
//  sample_i  in   valid/ready        position, target, now_ms, clear
//  result_o  out  valid/ready        drive_write, drive, reached
//  APB       in   psel/penable/...   8 registers at 4*index, 32-bit data
//
// One sample is accepted every cycle while the result side does not stall; its
// result passes through the sample register, then the result register.
// The integral, previous error and update time stamp are read and rewritten
// in the same cycle as the PID arithmetic, so each sample sees its
// predecessor's state. A stalled result holds and the sample register keeps
// taking one more request. Reset clears valid flags and state and presets the registers.
`default_nettype none

module rack_position_pid import rpp_pkg::*; #(
  parameter int PosMin        = PosMinDef,
  parameter int PosMax        = PosMaxDef,
  parameter int IntegralLimit = IntegralLimitDef,
  parameter int UpdateMs      = UpdateMsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  rpp_sample_if.sink            sample_i,
  rpp_result_if.source          result_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  localparam logic signed [PosW-1:0]  PosMinC = PosW'(PosMin);
  localparam logic signed [PosW-1:0]  PosMaxC = PosW'(PosMax);
  localparam logic signed [18:0]      IntLimC = 19'(IntegralLimit);
  localparam logic        [TimeW-1:0] UpdC    = TimeW'(UpdateMs);
  localparam logic        [16:0]      NearC   = 17'(NearBand);

  // Configuration registers.
  logic [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [LimW-1:0]  limit_up_q, limit_down_q, hold_drive_q, min_drive_q;
  logic [TolW-1:0]  tolerance_q;
  reg_idx_e         reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= GainPRst;
      gain_i_q     <= GainIRst;
      gain_d_q     <= GainDRst;
      limit_up_q   <= LimitUpRst;
      limit_down_q <= LimitDownRst;
      hold_drive_q <= HoldDriveRst;
      min_drive_q  <= MinDriveRst;
      tolerance_q  <= ToleranceRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegGainP:     gain_p_q     <= pwdata[GainW-1:0];
        RegGainI:     gain_i_q     <= pwdata[GainW-1:0];
        RegGainD:     gain_d_q     <= pwdata[GainW-1:0];
        RegLimitUp:   limit_up_q   <= pwdata[LimW-1:0];
        RegLimitDown: limit_down_q <= pwdata[LimW-1:0];
        RegHoldDrive: hold_drive_q <= pwdata[LimW-1:0];
        RegMinDrive:  min_drive_q  <= pwdata[LimW-1:0];
        RegTolerance: tolerance_q  <= pwdata[TolW-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegGainP:     prdata = DataW'(gain_p_q);
      RegGainI:     prdata = DataW'(gain_i_q);
      RegGainD:     prdata = DataW'(gain_d_q);
      RegLimitUp:   prdata = DataW'(limit_up_q);
      RegLimitDown: prdata = DataW'(limit_down_q);
      RegHoldDrive: prdata = DataW'(hold_drive_q);
      RegMinDrive:  prdata = DataW'(min_drive_q);
      RegTolerance: prdata = DataW'(tolerance_q);
    endcase
  end

  // Sample register and handshake.
  logic                   s1_valid_q;
  logic signed [PosW-1:0] s1_pos_q, s1_tgt_q;
  logic [TimeW-1:0]       s1_now_q;
  logic                   s1_clear_q;
  logic                   res_valid_q;
  logic                   in_acc, adv;

  assign adv            = s1_valid_q && (!res_valid_q || result_o.ready);
  assign sample_i.ready = !s1_valid_q || adv;
  assign in_acc         = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pos_q   <= sample_i.position;
      s1_tgt_q   <= sample_i.target;
      s1_now_q   <= sample_i.now_ms;
      s1_clear_q <= sample_i.clear;
    end
  end

  // Controller state.
  logic signed [IntW-1:0] integral_q, integral_d;
  logic signed [17:0]     err_last_q, err_last_d;
  logic [TimeW-1:0]       last_ms_q, last_ms_d;

  // PID datapath.
  logic signed [IntW-1:0]   int_eff;
  logic signed [17:0]       prev_eff;
  logic signed [PosW-1:0]   tgt_cl;
  logic signed [17:0]       err;
  logic [16:0]              mag;
  logic [16:0]              tol_ext;
  logic                     hold, elapsed;
  logic signed [17:0]       hold_thr;
  logic signed [18:0]       int_sum;
  logic signed [18:0]       deriv;
  logic signed [37:0]       prod_p, prod_i, prod_d, pid_sum;
  logic [LimW-1:0]          lim;
  logic signed [37:0]       lim_s, quo;
  logic signed [DriveW-1:0] drv_pid, drv_lim;
  logic [DriveW-1:0]        drv_mag;
  logic signed [DriveW-1:0] drive_d;
  logic                     write_d, reached_d;

  always_comb begin
    int_eff  = s1_clear_q ? '0 : integral_q;
    prev_eff = s1_clear_q ? '0 : err_last_q;

    if (s1_tgt_q > PosMaxC) begin
      tgt_cl = PosMaxC;
    end else if (s1_tgt_q < PosMinC) begin
      tgt_cl = PosMinC;
    end else begin
      tgt_cl = s1_tgt_q;
    end

    err      = 18'(tgt_cl) - 18'(s1_pos_q);
    mag      = err[17] ? 17'(-err) : 17'(err);
    tol_ext  = 17'(tolerance_q);
    hold     = mag < tol_ext;
    hold_thr = 18'(PosMinC) + $signed({10'b0, tolerance_q});
    elapsed  = (s1_now_q - last_ms_q) >= UpdC;

    // Conditional integration, clamped to the integral limit.
    int_sum = 19'(int_eff) + 19'(err);
    if (mag >= NearC) begin
      int_sum = '0;
    end else if (int_sum > IntLimC) begin
      int_sum = IntLimC;
    end else if (int_sum < -IntLimC) begin
      int_sum = -IntLimC;
    end

    deriv   = 19'(err) - 19'(prev_eff);
    prod_p  = 38'($signed({1'b0, gain_p_q}) * err);
    prod_i  = 38'($signed({1'b0, gain_i_q}) * $signed(int_sum[IntW-1:0]));
    prod_d  = 38'($signed({1'b0, gain_d_q}) * deriv);
    pid_sum = prod_p + prod_i + prod_d;

    lim   = (err > 18'sd0) ? limit_up_q : limit_down_q;
    lim_s = $signed({20'b0, lim, 8'b0});
    // Arithmetic shift rounds down; bump negative values with a remainder
    // to get truncation toward zero.
    quo = pid_sum >>> 8;
    if (pid_sum[37] && (pid_sum[7:0] != 8'd0)) begin
      quo = quo + 38'sd1;
    end
    drv_pid = quo[DriveW-1:0];
    if (pid_sum > lim_s) begin
      drv_lim = $signed({1'b0, lim});
    end else if (pid_sum < -lim_s) begin
      drv_lim = -$signed({1'b0, lim});
    end else begin
      drv_lim = drv_pid;
    end

    // Minimum-drive floor outside tolerance; it may exceed the limit.
    drv_mag = drv_lim[DriveW-1] ? DriveW'(-drv_lim) : DriveW'(drv_lim);
    drive_d = drv_lim;
    if ((mag > tol_ext) && (drv_lim != '0) && (drv_mag < {1'b0, min_drive_q})) begin
      drive_d = drv_lim[DriveW-1] ? -$signed({1'b0, min_drive_q})
                                  : $signed({1'b0, min_drive_q});
    end

    integral_d = int_eff;
    err_last_d = prev_eff;
    last_ms_d  = last_ms_q;
    write_d    = 1'b1;
    reached_d  = 1'b0;
    if (hold) begin
      reached_d  = 1'b1;
      err_last_d = '0;
      drive_d    = (18'(tgt_cl) > hold_thr) ? $signed({1'b0, hold_drive_q}) : '0;
    end else if (!elapsed) begin
      write_d = 1'b0;
      drive_d = '0;
    end else begin
      integral_d = int_sum[IntW-1:0];
      err_last_d = err;
      last_ms_d  = s1_now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      err_last_q <= '0;
      last_ms_q  <= '0;
    end else if (adv) begin
      integral_q <= integral_d;
      err_last_q <= err_last_d;
      last_ms_q  <= last_ms_d;
    end
  end

  // Result register.
  logic                     res_write_q, res_reached_q;
  logic signed [DriveW-1:0] res_drive_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_write_q   <= write_d;
      res_drive_q   <= drive_d;
      res_reached_q <= reached_d;
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.drive_write = res_write_q;
  assign result_o.drive       = res_drive_q;
  assign result_o.reached     = res_reached_q;

endmodule

`default_nettype wire

// ----- rtl/core/rpp_checker.sv -----
// Port-level checks for the rack position PID controller and the bind that
// attaches them to rack_position_pid. Depends on rpp_pkg and rpp_if.sv.
`default_nettype none

module rpp_checker import rpp_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     res_valid_i,
  input wire logic                     res_ready_i,
  input wire logic                     drive_write_i,
  input wire logic signed [DriveW-1:0] drive_i,
  input wire logic                     reached_i
);

  // A stalled result stays offered with the same drive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(drive_i))
    else $error("stalled result changed");

  // A skipped update carries no drive and no reached flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !drive_write_i |-> (drive_i == '0) && !reached_i)
    else $error("skipped update carries a drive");

  // Reaching the target always issues a drive value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && reached_i |-> drive_write_i)
    else $error("reached without drive write");

  // The drive never takes the one code outside its magnitude range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> drive_i != {1'b1, {(DriveW-1){1'b0}}})
    else $error("drive out of range");

endmodule

bind rack_position_pid rpp_checker u_rpp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (result_o.valid),
  .res_ready_i   (result_o.ready),
  .drive_write_i (result_o.drive_write),
  .drive_i       (result_o.drive),
  .reached_i     (result_o.reached)
);

`default_nettype wire

// ----- tb/rpp_drive_checker.sv -----
// Scoreboard for the rack position PID controller: watches the sample, result and
// register-write traffic, predicts each drive result and compares it field by field.
// Depends on rpp_pkg and the channel interfaces in rpp_if.sv.
module rpp_drive_checker import rpp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  rpp_sample_if            smp,
  rpp_result_if            res,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic             pready,
  output int               mismatches_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                     drive_write;
    logic signed [DriveW-1:0] drive;
    logic                     reached;
  } drive_res_t;

  // Register copies, written whenever the APB port writes.
  int gain_p, gain_i, gain_d, lim_up, lim_down, hold_drv, min_drv, tol;

  // Controller state.
  int               integ_sum;
  int               err_last;
  logic [TimeW-1:0] last_ms;

  drive_res_t expected_q[$];
  int         result_cnt;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    result_cnt   = 0;
  end

  task automatic report_mismatch(input string what);
    $display("rpp mismatch at result %0d: %s", result_cnt, what);
    mismatches_o++;
  endtask

  function automatic drive_res_t predict_drive(input logic signed [PosW-1:0] pos_in,
                                               input logic signed [PosW-1:0] tgt_in,
                                               input logic [TimeW-1:0] now,
                                               input logic clr);
    int               tgt, err, mag, lim, drv;
    longint           acc, deriv;
    logic [TimeW-1:0] elapsed;
    drive_res_t       r;
    if (clr) begin
      integ_sum = 0;
      err_last  = 0;
    end
    tgt = int'(tgt_in);
    if (tgt > PosMaxDef) tgt = PosMaxDef;
    if (tgt < PosMinDef) tgt = PosMinDef;
    err = tgt - int'(pos_in);
    mag = (err < 0) ? -err : err;

    if (mag < tol) begin
      r.drive_write = 1'b1;
      r.reached     = 1'b1;
      r.drive       = (tgt > PosMinDef + tol) ? DriveW'(hold_drv) : '0;
      err_last      = 0;
      return r;
    end

    elapsed = now - last_ms;
    if (elapsed < TimeW'(UpdateMsDef)) begin
      r = '0;
      return r;
    end
    last_ms = now;

    // Integrate only close to the target; far away the integral is dropped.
    if (mag < NearBand) begin
      integ_sum += err;
      if (integ_sum > IntegralLimitDef) integ_sum = IntegralLimitDef;
      if (integ_sum < -IntegralLimitDef) integ_sum = -IntegralLimitDef;
    end else begin
      integ_sum = 0;
    end

    deriv    = longint'(err) - longint'(err_last);
    err_last = err;
    acc = longint'(gain_p) * err + longint'(gain_i) * integ_sum + longint'(gain_d) * deriv;

    lim = (err > 0) ? lim_up : lim_down;
    if (acc > longint'(lim) * 256) begin
      drv = lim;
    end else if (acc < -longint'(lim) * 256) begin
      drv = -lim;
    end else begin
      drv = int'(acc / 256);
    end

    // The floor comes after the limit, so it may push past it.
    if (mag > tol) begin
      if (drv > 0 && drv < min_drv) drv = min_drv;
      if (drv < 0 && drv > -min_drv) drv = -min_drv;
    end

    r.drive_write = 1'b1;
    r.reached     = 1'b0;
    r.drive       = DriveW'(drv);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    drive_res_t want;
    if (!rst_ni) begin
      gain_p    = int'(GainPRst);
      gain_i    = int'(GainIRst);
      gain_d    = int'(GainDRst);
      lim_up    = int'(LimitUpRst);
      lim_down  = int'(LimitDownRst);
      hold_drv  = int'(HoldDriveRst);
      min_drv   = int'(MinDriveRst);
      tol       = int'(ToleranceRst);
      integ_sum = 0;
      err_last  = 0;
      last_ms   = '0;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[AddrW-1:2]))
          RegGainP:     gain_p   = int'(pwdata[GainW-1:0]);
          RegGainI:     gain_i   = int'(pwdata[GainW-1:0]);
          RegGainD:     gain_d   = int'(pwdata[GainW-1:0]);
          RegLimitUp:   lim_up   = int'(pwdata[LimW-1:0]);
          RegLimitDown: lim_down = int'(pwdata[LimW-1:0]);
          RegHoldDrive: hold_drv = int'(pwdata[LimW-1:0]);
          RegMinDrive:  min_drv  = int'(pwdata[LimW-1:0]);
          RegTolerance: tol      = int'(pwdata[TolW-1:0]);
          default: ;
        endcase
      end

      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result drive_write=%0b drive=%0d reached=%0b",
                                    res.drive_write, res.drive, res.reached));
        end else begin
          want = expected_q.pop_front();
          if (res.drive_write !== want.drive_write)
            report_mismatch($sformatf("drive_write %0b, expected %0b",
                                      res.drive_write, want.drive_write));
          if (res.drive !== want.drive)
            report_mismatch($sformatf("drive %0d, expected %0d", res.drive, want.drive));
          if (res.reached !== want.reached)
            report_mismatch($sformatf("reached %0b, expected %0b", res.reached, want.reached));
        end
        result_cnt++;
      end

      if (smp.valid && smp.ready)
        expected_q.push_back(predict_drive(smp.position, smp.target, smp.now_ms, smp.clear));

      pending_o = expected_q.size();
    end
  end

endmodule

// ----- tb/tb_rack_position_pid.sv -----
// Testbench top for the rack position PID controller: clock, reset, sample and
// register stimulus, result-side back-pressure and the final verdict.
// Depends on rpp_pkg, rpp_if.sv, rack_position_pid and rpp_drive_checker.
module tb_rack_position_pid;
  import rpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit       = 400000;
  localparam int ResultHoldCycles = 300;
  localparam int ItemsPerPhase    = 250;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int               mismatches;
  int               pending;
  int               cycle_cnt = 0;
  int               tol_now;
  logic [TimeW-1:0] ms_clock;
  bit               calm     = 1'b0;
  bit               hold_req = 1'b0;

  rpp_sample_if smp_if ();
  rpp_result_if res_if ();

  rack_position_pid DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  rpp_drive_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp          (smp_if),
    .res          (res_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("rack_position_pid regression: fail");
      $finish;
    end
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        for (int c = 1; c < ResultHoldCycles; c++) @(negedge clk_i);
      end else begin
        res_if.ready <= calm || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // Offers one request and returns at the edge that accepts it.
  task automatic send_sample(input int pos, input int tgt, input logic [TimeW-1:0] now,
                             input logic clr);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 7) begin
      smp_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp_if.valid    <= 1'b1;
    smp_if.position <= PosW'(pos);
    smp_if.target   <= PosW'(tgt);
    smp_if.now_ms   <= now;
    smp_if.clear    <= clr;
    do @(posedge clk_i); while (!smp_if.ready);
  endtask

  task automatic drain;
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input int unsigned val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= DataW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int gp, input int gi, input int gd, input int lu,
                            input int ld, input int hd, input int md, input int tl);
    drain();
    repeat (4) @(negedge clk_i);
    apb_write(RegGainP, gp);
    apb_write(RegGainI, gi);
    apb_write(RegGainD, gd);
    apb_write(RegLimitUp, lu);
    apb_write(RegLimitDown, ld);
    apb_write(RegHoldDrive, hd);
    apb_write(RegMinDrive, md);
    apb_write(RegTolerance, tl);
    tol_now = tl;
  endtask

  function automatic int pick_gain();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2047);
  endfunction

  // Mostly an axis tracking a target with bounded error and a ticking clock; the rest is
  // positions at the tolerance edge, wild positions and targets, and jumps of the time stamp.
  task automatic run_random_samples(input int count);
    int   kind, base, offset, pos, tgt;
    logic clr;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      clr  = ($urandom_range(0, 99) < 5);
      base = $urandom_range(0, PosMaxDef);
      tgt  = base;
      case ($urandom_range(0, 3))
        0:       offset = int'($urandom_range(0, 2 * tol_now + 4)) - tol_now - 2;
        1, 2:    offset = int'($urandom_range(0, 600)) - 300;
        default: offset = int'($urandom_range(0, 8000)) - 4000;
      endcase
      if (kind < 60) begin
        // Targets past either limit get clamped; the position stays near the clamp.
        if ($urandom_range(0, 9) == 0) tgt = base + int'($urandom_range(0, 400)) - 200;
        pos = base - offset;
        ms_clock += $urandom_range(0, 8);
      end else if (kind < 75) begin
        case ($urandom_range(0, 4))
          0:       pos = base - tol_now;
          1:       pos = base + tol_now;
          2:       pos = base - tol_now + 1;
          3:       pos = base + tol_now - 1;
          default: pos = base - tol_now - 1;
        endcase
        ms_clock += $urandom_range(0, 8);
      end else if (kind < 90) begin
        pos = int'($urandom_range(0, 65535)) - 32768;
        tgt = int'($urandom_range(0, 65535)) - 32768;
        ms_clock += $urandom_range(0, 20);
      end else begin
        pos      = base - offset;
        ms_clock = $urandom();
      end
      send_sample(pos, tgt, ms_clock, clr);
    end
  endtask

  initial begin
    int t;
    rst_ni          = 1'b0;
    smp_if.valid    <= 1'b0;
    smp_if.position <= '0;
    smp_if.target   <= '0;
    smp_if.now_ms   <= '0;
    smp_if.clear    <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    tol_now         = int'(ToleranceRst);
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, with the reset register values.
    send_sample(0, 0, 0, 1'b0);                // hold at the bottom: zero drive
    send_sample(500, 505, 0, 1'b0);            // hold above the bottom: hold drive
    send_sample(100, 400, 3, 1'b0);            // update interval not yet over
    send_sample(100, 400, 5, 1'b0);            // far error, upper limit
    send_sample(-32768, 32767, 10, 1'b0);      // both fields at their extremes
    send_sample(32767, -32768, 15, 1'b0);      // and the other way round
    send_sample(1000, 1010, 20, 1'b0);         // error equal to tolerance, no floor
    send_sample(1000, 1011, 25, 1'b0);         // just outside tolerance
    t = 30;
    for (int k = 0; k < 6; k++) begin
      send_sample(1000, 1200, t, 1'b0);        // integral runs into its clamp
      t += 5;
    end
    send_sample(1000, 1100, t, 1'b1);          // clear before the update
    send_sample(1000, 1100, 32'hFFFF_FFFF, 1'b0);
    send_sample(1000, 1400, 0, 1'b0);          // time stamp wrapped, interval not over
    send_sample(1000, 1400, 4, 1'b0);          // interval over across the wrap
    send_sample(1050, 1000, 9, 1'b0);          // negative error, lower limit
    send_sample(1002, 1000, 14, 1'b0);         // small negative error inside tolerance: hold drive
    send_sample(1795, 2000, 19, 1'b0);         // target above the top, held
    send_sample(3, -5, 24, 1'b0);              // target below the bottom, held at zero
    ms_clock = 32'd100;

    set_config(GainPRst, GainIRst, GainDRst, LimitUpRst, LimitDownRst, HoldDriveRst,
               MinDriveRst, ToleranceRst);
    run_random_samples(60);
    hold_req = 1'b1;                           // long result stall while requests go on
    run_random_samples(90);
    drain();                                   // sender waits for every result
    run_random_samples(150);

    set_config(65535, 65535, 65535, 1023, 1023, 1023, 1023, 255);
    ms_clock = 32'hFFFF_FF00;
    run_random_samples(ItemsPerPhase);

    set_config(0, 0, 0, 0, 0, 0, 0, 0);
    run_random_samples(ItemsPerPhase);

    for (int ph = 0; ph < 3; ph++) begin
      set_config(pick_gain(), pick_gain(), pick_gain(), $urandom_range(0, 1023),
                 $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 200),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40));
      calm = (ph == 0);
      run_random_samples(ItemsPerPhase);
      calm = 1'b0;
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("rack_position_pid regression: pass");
    end else begin
      $display("rack_position_pid regression: fail");
    end
    $finish;
  end

endmodule
